[design/etm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// etm_pkg
// Types, constants and helper functions shared by the transform matrix
// block and its pipeline stages.
// ----------------------------------------------------------------------------
package etm_pkg;

    localparam int ETM_CORDIC_STAGES = 16;
    localparam int MAX_ITERS         = 24;
    localparam int NUM_LANES         = 3;
    localparam int NUM_ROWS          = 3;

    localparam int ANG_W   = 16;
    localparam int SCALE_W = 16;
    localparam int SHIFT_W = 32;
    localparam int CORD_W  = 34;
    localparam int TRIG_W  = 32;
    localparam int ROT_W   = 33;
    localparam int DIV_BITS = 25;
    localparam int DEN_W   = 16;
    localparam int K_W     = 26;
    localparam int PROD_W  = ROT_W + K_W;
    localparam int OUT_W   = 32;

    localparam logic [1:0] OP_FULL   = 2'd0;
    localparam logic [1:0] OP_ROT    = 2'd1;
    localparam logic [1:0] OP_NORMAL = 2'd2;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd2;

    localparam int SHIFT_SCALED = 22;
    localparam int SHIFT_NORMAL = 30;

    localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [31:0] ATAN_TAB [MAX_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [1:0]                 operation;
        logic signed [ANG_W-1:0]    angle_x;
        logic signed [ANG_W-1:0]    angle_y;
        logic signed [ANG_W-1:0]    angle_z;
        logic signed [SCALE_W-1:0]  scale_x;
        logic signed [SCALE_W-1:0]  scale_y;
        logic signed [SCALE_W-1:0]  scale_z;
        logic signed [SHIFT_W-1:0]  shift_x;
        logic signed [SHIFT_W-1:0]  shift_y;
        logic signed [SHIFT_W-1:0]  shift_z;
    } etm_request_t;

    typedef struct packed {
        logic [1:0]               row_index;
        logic signed [OUT_W-1:0]  col0;
        logic signed [OUT_W-1:0]  col1;
        logic signed [OUT_W-1:0]  col2;
        logic signed [OUT_W-1:0]  col3;
        logic                     div_error;
        logic                     last_row;
    } etm_result_t;

    // One lane of the front pipeline: a CORDIC rotation and a divider.
    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [CORD_W-1:0] z;
        logic                     flip;
        logic [DEN_W-1:0]         rem;
        logic [DIV_BITS-1:0]      num;
        logic [DIV_BITS-1:0]      quo;
        logic [DEN_W-1:0]         den;
    } etm_lane_t;

    typedef struct packed {
        logic [1:0]                           op;
        logic signed [SHIFT_W-1:0]            shift_x;
        logic signed [SHIFT_W-1:0]            shift_y;
        logic signed [SHIFT_W-1:0]            shift_z;
        logic [NUM_LANES-1:0]                 neg;
        logic [NUM_LANES-1:0]                 zero;
        logic [NUM_LANES-1:0][SCALE_W-1:0]    scale;
    } etm_side_t;

    // Product of two Q30 values, floored back to Q30.
    function automatic logic signed [TRIG_W-1:0] mul30(
        input logic signed [TRIG_W-1:0] a,
        input logic signed [TRIG_W-1:0] b
    );
        logic signed [2*TRIG_W-1:0] p;
        p = a * b;
        return TRIG_W'(p >>> 30);
    endfunction

    function automatic logic signed [OUT_W-1:0] sat32(
        input logic signed [PROD_W:0] v
    );
        logic signed [PROD_W:0] hi;
        logic signed [PROD_W:0] lo;
        hi = (PROD_W+1)'(64'sh7FFFFFFF);
        lo = -hi - 1;
        if (v > hi)
            return {1'b0, {(OUT_W-1){1'b1}}};
        else if (v < lo)
            return {1'b1, {(OUT_W-1){1'b0}}};
        else
            return OUT_W'(v);
    endfunction

endpackage
`default_nettype wire

[design/etm_front_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// etm_front_stage
// One register stage of a front lane: one CORDIC micro-rotation (while the
// stage index is below the iteration count) and one restoring divide step.
// ----------------------------------------------------------------------------
module etm_front_stage
    import etm_pkg::*;
#(
    parameter int STAGE_IDX     = 0,
    parameter int CORDIC_STAGES = ETM_CORDIC_STAGES
)
(
    input  wire logic      clk,
    input  etm_lane_t      lane_in,
    output etm_lane_t      lane_out
);

    localparam bit DO_ROT   = (STAGE_IDX < CORDIC_STAGES) && (STAGE_IDX < MAX_ITERS);
    localparam int ATAN_IDX = (STAGE_IDX < MAX_ITERS) ? STAGE_IDX : 0;

    etm_lane_t lane_reg;
    etm_lane_t lane_next;

    always_comb
    begin
        logic signed [CORD_W-1:0] atan_v;
        logic [DEN_W:0]           rs;
        logic                     qbit;
        lane_next = lane_in;
        atan_v    = CORD_W'($signed({1'b0, ATAN_TAB[ATAN_IDX]}));
        if (DO_ROT)
        begin
            if (!lane_in.z[CORD_W-1])
            begin
                lane_next.x = lane_in.x - (lane_in.y >>> STAGE_IDX);
                lane_next.y = lane_in.y + (lane_in.x >>> STAGE_IDX);
                lane_next.z = lane_in.z - atan_v;
            end
            else
            begin
                lane_next.x = lane_in.x + (lane_in.y >>> STAGE_IDX);
                lane_next.y = lane_in.y - (lane_in.x >>> STAGE_IDX);
                lane_next.z = lane_in.z + atan_v;
            end
        end
        // The partial remainder stays below the divisor, so it fits DEN_W bits.
        rs = {lane_in.rem, lane_in.num[DIV_BITS-1]};
        if (rs >= {1'b0, lane_in.den})
        begin
            qbit          = 1'b1;
            lane_next.rem = DEN_W'(rs - {1'b0, lane_in.den});
        end
        else
        begin
            qbit          = 1'b0;
            lane_next.rem = rs[DEN_W-1:0];
        end
        lane_next.num = {lane_in.num[DIV_BITS-2:0], 1'b0};
        lane_next.quo = {lane_in.quo[DIV_BITS-2:0], qbit};
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule
`default_nettype wire

[design/euler_transform_matrix.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// euler_transform_matrix
// Builds the upper three rows of a scaled Y-X-Z Euler transform matrix.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// After that edge busy stays high, so no new request can be taken until it
// falls again; the pipeline itself holds up to twelve requests at once.
// Each request yields three rows. The first row is on the result port,
// marked by done, and the other two follow back to back, row_index 0, 1, 2
// with last_row on row 2.
// A request passes through the 25-stage front pipeline (one divide bit per
// stage and a CORDIC rotation in the first CORDIC_STAGES stages, three lanes
// side by side), then four stages of sine and cosine, products and sums, and
// a row sequencer that drives three multipliers, one row per cycle.
// Rows cannot be held off: each is valid for exactly one cycle.
// Reset clears all valid flags and the busy counter; no row is emitted
// until a request has been taken after reset.
// ----------------------------------------------------------------------------
module euler_transform_matrix
    import etm_pkg::*;
#(
    parameter int CORDIC_STAGES = ETM_CORDIC_STAGES
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  etm_request_t  request,
    output logic          done,
    output etm_result_t   result
);

    localparam logic [1:0] GAP = 2'(NUM_ROWS - 1);

    logic        accept;
    logic [1:0]  gap_reg;
    logic [1:0]  gap_next;

    assign accept = start && !busy;
    assign busy   = (gap_reg != 2'd0);

    always_comb
    begin
        if (accept)
            gap_next = GAP;
        else if (gap_reg != 2'd0)
            gap_next = gap_reg - 2'd1;
        else
            gap_next = gap_reg;
    end

    // ---------------------------------------------------------------- front
    logic signed [ANG_W-1:0]   lane_angle [NUM_LANES];
    logic signed [SCALE_W-1:0] lane_scale [NUM_LANES];
    etm_lane_t                 lane0_reg  [NUM_LANES];
    etm_lane_t                 lane0_next [NUM_LANES];
    etm_lane_t                 lane_pipe  [NUM_LANES][DIV_BITS+1];
    etm_side_t                 side_reg   [DIV_BITS+1];
    etm_side_t                 side_next;
    logic [DIV_BITS:0]         valid_reg;

    assign lane_angle[0] = request.angle_y;
    assign lane_angle[1] = request.angle_x;
    assign lane_angle[2] = request.angle_z;
    assign lane_scale[0] = request.scale_x;
    assign lane_scale[1] = request.scale_y;
    assign lane_scale[2] = request.scale_z;

    always_comb
    begin
        logic             flip;
        logic [31:0]      z32;
        logic [DEN_W-1:0] mag;
        side_next.op      = request.operation;
        side_next.shift_x = request.shift_x;
        side_next.shift_y = request.shift_y;
        side_next.shift_z = request.shift_z;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            // Angles in the second and third quadrant are turned by half a turn.
            flip = lane_angle[j][ANG_W-1] ^ lane_angle[j][ANG_W-2];
            z32  = {lane_angle[j][ANG_W-1] ^ flip, lane_angle[j][ANG_W-2:0], 16'd0};
            mag  = lane_scale[j][SCALE_W-1] ? DEN_W'(~lane_scale[j] + 16'sd1)
                                            : DEN_W'(lane_scale[j]);
            lane0_next[j].x    = CORDIC_X0;
            lane0_next[j].y    = '0;
            lane0_next[j].z    = CORD_W'($signed(z32));
            lane0_next[j].flip = flip;
            lane0_next[j].rem  = '0;
            lane0_next[j].num  = (DIV_BITS'(1) << 24) + DIV_BITS'(mag >> 1);
            lane0_next[j].quo  = '0;
            lane0_next[j].den  = mag;
            side_next.neg[j]   = lane_scale[j][SCALE_W-1];
            side_next.zero[j]  = (lane_scale[j] == 16'sd0);
            side_next.scale[j] = lane_scale[j];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_LANES; j++)
        begin
            lane0_reg[j] <= lane0_next[j];
        end
        side_reg[0] <= side_next;
        for (int g = 1; g <= DIV_BITS; g++)
        begin
            side_reg[g] <= side_reg[g-1];
        end
    end

    for (genvar j = 0; j < NUM_LANES; j++)
    begin : g_lane
        assign lane_pipe[j][0] = lane0_reg[j];
        for (genvar g = 0; g < DIV_BITS; g++)
        begin : g_stage
            etm_front_stage #(
                .STAGE_IDX     (g),
                .CORDIC_STAGES (CORDIC_STAGES)
            ) u_stage (
                .clk      (clk),
                .lane_in  (lane_pipe[j][g]),
                .lane_out (lane_pipe[j][g+1])
            );
        end
    end

    // -------------------------------------------------- sine, cosine, factor
    logic signed [TRIG_W-1:0] c_reg [NUM_LANES];
    logic signed [TRIG_W-1:0] s_reg [NUM_LANES];
    logic signed [K_W-1:0]    k_reg [NUM_LANES];
    etm_side_t                e_side_reg;
    logic                     e_err_reg;
    logic                     e_valid_reg;

    always_ff @(posedge clk)
    begin
        logic signed [CORD_W-1:0] xv;
        logic signed [CORD_W-1:0] yv;
        logic signed [K_W-1:0]    qv;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            xv = lane_pipe[j][DIV_BITS].x;
            yv = lane_pipe[j][DIV_BITS].y;
            qv = $signed({1'b0, lane_pipe[j][DIV_BITS].quo});
            c_reg[j] <= TRIG_W'(lane_pipe[j][DIV_BITS].flip ? -xv : xv);
            s_reg[j] <= TRIG_W'(lane_pipe[j][DIV_BITS].flip ? -yv : yv);
            if (side_reg[DIV_BITS].op == OP_NORMAL)
            begin
                if (side_reg[DIV_BITS].zero[j])
                    k_reg[j] <= '0;
                else
                    k_reg[j] <= side_reg[DIV_BITS].neg[j] ? -qv : qv;
            end
            else
            begin
                k_reg[j] <= K_W'($signed(side_reg[DIV_BITS].scale[j]));
            end
        end
        e_side_reg <= side_reg[DIV_BITS];
        e_err_reg  <= (side_reg[DIV_BITS].op == OP_NORMAL) && (|side_reg[DIV_BITS].zero);
    end

    // ------------------------------------------------------------ products
    logic signed [TRIG_W-1:0] a_c1c3_reg, a_s1s2_reg, a_s1s3_reg, a_c2s1_reg, a_c2s3_reg;
    logic signed [TRIG_W-1:0] a_c2c3_reg, a_s2s3_reg, a_c1c2_reg, a_c3s1_reg, a_c1s3_reg;
    logic signed [TRIG_W-1:0] a_c1_reg, a_c3_reg, a_s2_reg, a_s3_reg;
    logic signed [K_W-1:0]    a_k_reg [NUM_LANES];
    etm_side_t                a_side_reg;
    logic                     a_err_reg;
    logic                     a_valid_reg;

    always_ff @(posedge clk)
    begin
        a_c1c3_reg <= mul30(c_reg[0], c_reg[2]);
        a_s1s2_reg <= mul30(s_reg[0], s_reg[1]);
        a_s1s3_reg <= mul30(s_reg[0], s_reg[2]);
        a_c2s1_reg <= mul30(c_reg[1], s_reg[0]);
        a_c2s3_reg <= mul30(c_reg[1], s_reg[2]);
        a_c2c3_reg <= mul30(c_reg[1], c_reg[2]);
        a_s2s3_reg <= mul30(s_reg[1], s_reg[2]);
        a_c1c2_reg <= mul30(c_reg[0], c_reg[1]);
        a_c3s1_reg <= mul30(c_reg[2], s_reg[0]);
        a_c1s3_reg <= mul30(c_reg[0], s_reg[2]);
        a_c1_reg   <= c_reg[0];
        a_c3_reg   <= c_reg[2];
        a_s2_reg   <= s_reg[1];
        a_s3_reg   <= s_reg[2];
        a_k_reg    <= k_reg;
        a_side_reg <= e_side_reg;
        a_err_reg  <= e_err_reg;
    end

    logic signed [TRIG_W-1:0] b_s1s2s3_reg, b_s1s2c3_reg, b_s2s3c1_reg, b_c1c3s2_reg;
    logic signed [TRIG_W-1:0] b_c1c3_reg, b_c1s3_reg, b_c3s1_reg, b_s1s3_reg;
    logic signed [TRIG_W-1:0] b_c2s1_reg, b_c2s3_reg, b_c2c3_reg, b_s2_reg, b_c1c2_reg;
    logic signed [K_W-1:0]    b_k_reg [NUM_LANES];
    etm_side_t                b_side_reg;
    logic                     b_err_reg;
    logic                     b_valid_reg;

    always_ff @(posedge clk)
    begin
        b_s1s2s3_reg <= mul30(a_s1s2_reg, a_s3_reg);
        b_s1s2c3_reg <= mul30(a_s1s2_reg, a_c3_reg);
        b_s2s3c1_reg <= mul30(a_s2s3_reg, a_c1_reg);
        b_c1c3s2_reg <= mul30(a_c1c3_reg, a_s2_reg);
        b_c1c3_reg   <= a_c1c3_reg;
        b_c1s3_reg   <= a_c1s3_reg;
        b_c3s1_reg   <= a_c3s1_reg;
        b_s1s3_reg   <= a_s1s3_reg;
        b_c2s1_reg   <= a_c2s1_reg;
        b_c2s3_reg   <= a_c2s3_reg;
        b_c2c3_reg   <= a_c2c3_reg;
        b_s2_reg     <= a_s2_reg;
        b_c1c2_reg   <= a_c1c2_reg;
        b_k_reg      <= a_k_reg;
        b_side_reg   <= a_side_reg;
        b_err_reg    <= a_err_reg;
    end

    logic signed [ROT_W-1:0] rot_reg [NUM_ROWS][NUM_LANES];
    logic signed [K_W-1:0]   r_k_reg [NUM_LANES];
    etm_side_t               r_side_reg;
    logic                    r_err_reg;
    logic                    r_valid_reg;

    always_ff @(posedge clk)
    begin
        rot_reg[0][0] <= ROT_W'(b_c1c3_reg) + ROT_W'(b_s1s2s3_reg);
        rot_reg[0][1] <= ROT_W'(b_s1s2c3_reg) - ROT_W'(b_c1s3_reg);
        rot_reg[0][2] <= ROT_W'(b_c2s1_reg);
        rot_reg[1][0] <= ROT_W'(b_c2s3_reg);
        rot_reg[1][1] <= ROT_W'(b_c2c3_reg);
        rot_reg[1][2] <= -ROT_W'(b_s2_reg);
        rot_reg[2][0] <= ROT_W'(b_s2s3c1_reg) - ROT_W'(b_c3s1_reg);
        rot_reg[2][1] <= ROT_W'(b_c1c3s2_reg) + ROT_W'(b_s1s3_reg);
        rot_reg[2][2] <= ROT_W'(b_c1c2_reg);
        r_k_reg       <= b_k_reg;
        r_side_reg    <= b_side_reg;
        r_err_reg     <= b_err_reg;
    end

    // ------------------------------------------------------- row sequencer
    // Busy keeps requests far enough apart that the hold registers are
    // free again by the time the next matrix arrives.
    logic signed [ROT_W-1:0] h_rot_reg [NUM_ROWS][NUM_LANES];
    logic signed [K_W-1:0]   h_k_reg   [NUM_LANES];
    etm_side_t               h_side_reg;
    logic                    h_err_reg;
    logic [1:0]              row_reg;
    logic [1:0]              row_next;
    logic                    act_reg;
    logic                    act_next;

    always_ff @(posedge clk)
    begin
        if (r_valid_reg)
        begin
            h_rot_reg  <= rot_reg;
            h_k_reg    <= r_k_reg;
            h_side_reg <= r_side_reg;
            h_err_reg  <= r_err_reg;
        end
    end

    always_comb
    begin
        row_next = row_reg;
        act_next = act_reg;
        if (r_valid_reg)
        begin
            row_next = ROW_FIRST;
            act_next = 1'b1;
        end
        else if (act_reg)
        begin
            if (row_reg == ROW_LAST)
                act_next = 1'b0;
            else
                row_next = row_reg + 2'd1;
        end
    end

    logic signed [PROD_W-1:0]  m_prod_reg [NUM_LANES];
    logic [1:0]                m_row_reg;
    logic [1:0]                m_op_reg;
    logic signed [SHIFT_W-1:0] m_shift_reg;
    logic                      m_err_reg;
    logic                      m_valid_reg;
    logic signed [SHIFT_W-1:0] row_shift;

    always_comb
    begin
        case (row_reg)
            2'd0:    row_shift = h_side_reg.shift_x;
            2'd1:    row_shift = h_side_reg.shift_y;
            default: row_shift = h_side_reg.shift_z;
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_LANES; j++)
        begin
            m_prod_reg[j] <= PROD_W'(h_rot_reg[row_reg][j]) * PROD_W'(h_k_reg[j]);
        end
        m_row_reg   <= row_reg;
        m_op_reg    <= h_side_reg.op;
        m_shift_reg <= row_shift;
        m_err_reg   <= h_err_reg;
    end

    // ------------------------------------------------- rounding and output
    etm_result_t              result_reg;
    etm_result_t              result_next;
    logic signed [OUT_W-1:0]  col_v [NUM_LANES];

    always_comb
    begin
        logic signed [PROD_W:0] wide;
        logic signed [PROD_W:0] rnd;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            wide = (PROD_W+1)'(m_prod_reg[j]);
            if (m_op_reg == OP_NORMAL)
                rnd = (wide + ((PROD_W+1)'(1) <<< (SHIFT_NORMAL - 1))) >>> SHIFT_NORMAL;
            else
                rnd = (wide + ((PROD_W+1)'(1) <<< (SHIFT_SCALED - 1))) >>> SHIFT_SCALED;
            col_v[j] = sat32(rnd);
        end
        result_next.row_index = m_row_reg;
        result_next.col0      = col_v[0];
        result_next.col1      = col_v[1];
        result_next.col2      = col_v[2];
        result_next.col3      = (m_op_reg == OP_FULL) ? m_shift_reg : '0;
        result_next.div_error = m_err_reg;
        result_next.last_row  = (m_row_reg == ROW_LAST);
    end

    logic done_reg;

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // ------------------------------------------------------ control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg     <= '0;
            valid_reg   <= '0;
            e_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            row_reg     <= ROW_FIRST;
            act_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            gap_reg     <= gap_next;
            valid_reg   <= {valid_reg[DIV_BITS-1:0], accept};
            e_valid_reg <= valid_reg[DIV_BITS];
            a_valid_reg <= e_valid_reg;
            b_valid_reg <= a_valid_reg;
            r_valid_reg <= b_valid_reg;
            row_reg     <= row_next;
            act_reg     <= act_next;
            m_valid_reg <= act_reg;
            done_reg    <= m_valid_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire
